@@ hdl/i2cbm_pkg.sv @@
`default_nettype none

package i2cbm_pkg;

  // command codes carried by an input item
  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_READ     = 3'd3,
    OP_WAIT_ACK = 3'd4
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SHORT_DELAY = 2'd0,
    CFG_LONG_DELAY  = 2'd1,
    CFG_POLL_LIMIT  = 2'd2
  } cfg_idx_e;

  // sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_S1     = 5'd1,
    PH_S2     = 5'd2,
    PH_P1     = 5'd3,
    PH_P2     = 5'd4,
    PH_K1     = 5'd5,
    PH_K2     = 5'd6,
    PH_W_LOW  = 5'd7,
    PH_W_HIGH = 5'd8,
    PH_W_GAP  = 5'd9,
    PH_R_LOW  = 5'd10,
    PH_R_HIGH = 5'd11,
    PH_A_LOW  = 5'd12,
    PH_A_HIGH = 5'd13
  } phase_e;

  localparam logic [7:0] SHORT_DELAY_RST = 8'd10;
  localparam logic [7:0] LONG_DELAY_RST  = 8'd20;
  localparam logic [7:0] POLL_LIMIT_RST  = 8'd200;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

  // one tick as it enters the block
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       ack_after_read;
    logic       sda_in;
  } item_t;

  // line levels and status after one tick
  typedef struct packed {
    logic       scl_out;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_ok;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/i2cbm_in_stage.sv @@
`default_nettype none

module i2cbm_in_stage
  import i2cbm_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  wire   take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // free, or emptied by the core in this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ hdl/i2cbm_core.sv @@
`default_nettype none

module i2cbm_core
  import i2cbm_pkg::*;
#(
  parameter int DELAY_BITS = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire  [1:0] cfg_index_i,
  input  wire  [7:0] cfg_data_i,
  input  wire        step_i,
  input  item_t      item_i,
  output res_t       res_o
);

  localparam int CMP_W = (DELAY_BITS > 8) ? DELAY_BITS : 8;
  localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;
  localparam logic [DELAY_BITS-1:0] DELAY_ONE = DELAY_BITS'(1);

  // clamp a delay register to one tick at least and to the counter range
  function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [7:0] d);
    logic [7:0]       e;
    logic [CMP_W-1:0] w;
    e = (d == 8'd0) ? 8'd1 : d;
    w = CMP_W'(e);
    if (w > CMP_W'(DELAY_MAX)) begin
      return DELAY_MAX;
    end
    return DELAY_BITS'(w);
  endfunction

  logic [7:0] short_q, long_q, limit_q;

  phase_e                phase_q, phase_d;
  logic [3:0]            bit_q, bit_d;
  logic [DELAY_BITS-1:0] dly_q, dly_d;
  logic [7:0]            shift_q, shift_d;
  logic [7:0]            poll_q, poll_d;
  logic                  scl_q, scl_d;
  logic                  sda_rel_q, sda_rel_d;
  logic [7:0]            recv_q, recv_d;
  logic                  ack_res_q, ack_res_d;
  logic                  send_ack_q, send_ack_d;
  logic                  done;
  logic [DELAY_BITS-1:0] short_dly, long_dly;
  logic [3:0]            bit_inc;

  assign short_dly = sat_delay(short_q);
  assign long_dly  = sat_delay(long_q);
  assign bit_inc   = bit_q + 4'd1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= SHORT_DELAY_RST;
      long_q  <= LONG_DELAY_RST;
      limit_q <= POLL_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SHORT_DELAY: short_q <= cfg_data_i;
        CFG_LONG_DELAY:  long_q  <= cfg_data_i;
        CFG_POLL_LIMIT:  limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state for one tick
  always_comb begin
    phase_d    = phase_q;
    bit_d      = bit_q;
    dly_d      = dly_q;
    shift_d    = shift_q;
    poll_d     = poll_q;
    scl_d      = scl_q;
    sda_rel_d  = sda_rel_q;
    recv_d     = recv_q;
    ack_res_d  = ack_res_q;
    send_ack_d = send_ack_q;
    done       = 1'b0;
    if (phase_q == PH_IDLE) begin
      // command launch, unknown codes change nothing
      if (item_i.cmd_valid) begin
        unique case (item_i.op)
          OP_START: begin
            sda_rel_d = 1'b1;
            scl_d     = 1'b1;
            dly_d     = short_dly;
            phase_d   = PH_S1;
          end
          OP_STOP: begin
            scl_d     = 1'b0;
            sda_rel_d = 1'b0;
            dly_d     = short_dly;
            phase_d   = PH_P1;
          end
          OP_WRITE: begin
            bit_d     = 4'd0;
            scl_d     = 1'b0;
            sda_rel_d = item_i.tx_byte[7];
            shift_d   = {item_i.tx_byte[6:0], 1'b0};
            dly_d     = long_dly;
            phase_d   = PH_W_LOW;
          end
          OP_READ: begin
            shift_d    = 8'd0;
            bit_d      = 4'd0;
            sda_rel_d  = 1'b1;
            scl_d      = 1'b0;
            send_ack_d = item_i.ack_after_read;
            dly_d      = long_dly;
            phase_d    = PH_R_LOW;
          end
          OP_WAIT_ACK: begin
            sda_rel_d = 1'b1;
            scl_d     = 1'b1;
            poll_d    = 8'd0;
            dly_d     = short_dly;
            phase_d   = PH_K1;
          end
          default: ;
        endcase
      end
    end else if (dly_q > DELAY_ONE) begin
      dly_d = dly_q - DELAY_ONE;
    end else begin
      // step of the running sequence
      unique case (phase_q)
        PH_S1: begin
          sda_rel_d = 1'b0;
          dly_d     = short_dly;
          phase_d   = PH_S2;
        end
        PH_S2: begin
          scl_d   = 1'b0;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        PH_P1: begin
          scl_d   = 1'b1;
          dly_d   = short_dly;
          phase_d = PH_P2;
        end
        PH_P2: begin
          sda_rel_d = 1'b1;
          phase_d   = PH_IDLE;
          done      = 1'b1;
        end
        PH_K1, PH_K2: begin
          if (!item_i.sda_in) begin
            scl_d     = 1'b0;
            ack_res_d = 1'b1;
            phase_d   = PH_IDLE;
            done      = 1'b1;
          end else if (poll_q >= limit_q) begin
            // timeout runs a stop
            ack_res_d = 1'b0;
            scl_d     = 1'b0;
            sda_rel_d = 1'b0;
            dly_d     = short_dly;
            phase_d   = PH_P1;
          end else begin
            poll_d  = poll_q + 8'd1;
            dly_d   = short_dly;
            phase_d = PH_K2;
          end
        end
        PH_W_LOW: begin
          scl_d   = 1'b1;
          dly_d   = long_dly;
          phase_d = PH_W_HIGH;
        end
        PH_W_HIGH: begin
          scl_d   = 1'b0;
          dly_d   = short_dly;
          phase_d = PH_W_GAP;
        end
        PH_W_GAP: begin
          bit_d = bit_inc;
          if (bit_inc >= BITS_PER_BYTE) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else begin
            sda_rel_d = shift_q[7];
            shift_d   = {shift_q[6:0], 1'b0};
            dly_d     = long_dly;
            phase_d   = PH_W_LOW;
          end
        end
        PH_R_LOW: begin
          scl_d   = 1'b1;
          shift_d = {shift_q[6:0], item_i.sda_in};
          dly_d   = long_dly;
          phase_d = PH_R_HIGH;
        end
        PH_R_HIGH: begin
          bit_d = bit_inc;
          scl_d = 1'b0;
          if (bit_inc >= BITS_PER_BYTE) begin
            sda_rel_d = !send_ack_q;
            dly_d     = short_dly;
            phase_d   = PH_A_LOW;
          end else begin
            dly_d   = long_dly;
            phase_d = PH_R_LOW;
          end
        end
        PH_A_LOW: begin
          scl_d   = 1'b1;
          dly_d   = short_dly;
          phase_d = PH_A_HIGH;
        end
        PH_A_HIGH: begin
          scl_d   = 1'b0;
          recv_d  = shift_q;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // sequencer state, advances once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_q      <= 4'd0;
      dly_q      <= '0;
      shift_q    <= 8'd0;
      poll_q     <= 8'd0;
      scl_q      <= 1'b1;
      sda_rel_q  <= 1'b1;
      recv_q     <= 8'd0;
      ack_res_q  <= 1'b0;
      send_ack_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      bit_q      <= bit_d;
      dly_q      <= dly_d;
      shift_q    <= shift_d;
      poll_q     <= poll_d;
      scl_q      <= scl_d;
      sda_rel_q  <= sda_rel_d;
      recv_q     <= recv_d;
      ack_res_q  <= ack_res_d;
      send_ack_q <= send_ack_d;
    end
  end

  // result reflects the state after this tick
  always_comb begin
    res_o.scl_out      = scl_d;
    res_o.sda_pull_low = !sda_rel_d;
    res_o.busy_res     = (phase_d != PH_IDLE);
    res_o.done_res     = done;
    res_o.rx_byte      = recv_d;
    res_o.ack_ok       = ack_res_d;
  end

endmodule

`default_nettype wire

@@ hdl/i2cbm_out_stage.sv @@
`default_nettype none

module i2cbm_out_stage
  import i2cbm_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  load_i,
  input  res_t res_i,
  output logic can_take_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign can_take_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (can_take_o) begin
      valid_d = load_i;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i && can_take_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ hdl/i2c_bit_level_master_unit.sv @@
// Bit-level I2C master. Each input item is one tick of the bus sequencer: it may carry
// a command (start, stop, write byte, read byte with ACK or NACK, wait for ACK, taken
// only while idle) and always carries the sampled SDA level. Every item yields exactly
// one result item with the SCL level, the SDA pull-low drive, busy, done, the last
// received byte and the last ACK result, as they stand after that tick. Items are taken
// at one per cycle while the result register has room; an accepted item waits in the
// input register until then, and the single-pass next-state logic loads its result
// into the result register as the item moves on.
// Delays count ticks, not clock cycles, and saturate at 2^DELAY_BITS - 1. Configuration
// writes are meant for idle periods only.
`default_nettype none

module i2c_bit_level_master_unit
  import i2cbm_pkg::*;
#(
  parameter int DELAY_BITS = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire  [1:0] cfg_index_i,
  input  wire  [7:0] cfg_data_i,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire        cmd_valid_i,
  input  wire  [2:0] op_i,
  input  wire  [7:0] tx_byte_i,
  input  wire        ack_after_read_i,
  input  wire        sda_in_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic       scl_out_o,
  output logic       sda_pull_low_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] rx_byte_o,
  output logic       ack_ok_o
);

  item_t item_in, item_q;
  logic  in_valid_q;
  logic  can_take;
  logic  step;
  res_t  res_next, res_q;

  assign item_in = '{cmd_valid:      cmd_valid_i,
                     op:             op_i,
                     tx_byte:        tx_byte_i,
                     ack_after_read: ack_after_read_i,
                     sda_in:         sda_in_i};

  // a registered item moves on when the result register has room
  assign step = in_valid_q && can_take;

  i2cbm_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .take_i     (step),
    .valid_o    (in_valid_q),
    .item_o     (item_q)
  );

  i2cbm_core #(
    .DELAY_BITS (DELAY_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .item_i      (item_q),
    .res_o       (res_next)
  );

  i2cbm_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res_next),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign scl_out_o      = res_q.scl_out;
  assign sda_pull_low_o = res_q.sda_pull_low;
  assign busy_res_o     = res_q.busy_res;
  assign done_res_o     = res_q.done_res;
  assign rx_byte_o      = res_q.rx_byte;
  assign ack_ok_o       = res_q.ack_ok;

  // a completing tick never reports busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported together with busy");

  // an item handed to the core shows up as a result next cycle
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("stepped item produced no result");

  // input side stalls only when both stages are full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled with room in the pipe");

endmodule

`default_nettype wire
